### hw/rtl/abkf_pkg.sv
// Shared types, constants and fixed-point helpers of the angle and bias Kalman filter.
package abkf_pkg;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int QW = DW + FB;
  localparam int CW = $clog2(QW + 1);

  localparam logic signed [DW-1:0] MAX_V = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MIN_V = {1'b1, {(DW-1){1'b0}}};

  localparam logic [30:0] DT_RESET = 31'(((5 << FB) + 500) / 1000);
  localparam logic [30:0] QA_RESET = 31'(((2 << FB) + 5) / 10);
  localparam logic [30:0] QB_RESET = 31'(((1 << FB) + 5) / 10);
  localparam logic [30:0] RN_RESET = 31'(1 << (FB - 1));
  localparam logic [31:0] C_RESET  = 32'(1 << FB);
  localparam logic signed [DW-1:0] ONE_Q = DW'(1 << FB);

  typedef enum logic [2:0] {
    CFG_TIME_STEP     = 3'd0,
    CFG_ANGLE_NOISE   = 3'd1,
    CFG_BIAS_NOISE    = 3'd2,
    CFG_MEASURE_NOISE = 3'd3,
    CFG_OBSERVE_GAIN  = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_ANG_PRED  = 4'd0,
    OP_AA_PRED   = 4'd1,
    OP_AB_PRED   = 4'd2,
    OP_BA_PRED   = 4'd3,
    OP_BB_PRED   = 4'd4,
    OP_PC0       = 4'd5,
    OP_PC1       = 4'd6,
    OP_T1        = 4'd7,
    OP_E         = 4'd8,
    OP_AA_UPD    = 4'd9,
    OP_AB_UPD    = 4'd10,
    OP_BA_UPD    = 4'd11,
    OP_BB_UPD    = 4'd12,
    OP_ANG_UPD   = 4'd13,
    OP_BIAS_UPD  = 4'd14
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_WB, ST_DIVS, ST_DIV, ST_FIN
  } state_e;

  typedef struct packed {
    op_e  op;
    logic load_in;
    logic mul_en;
    logic wb_en;
    logic div_start;
    logic div_wb;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
  } status_t;

  function automatic logic signed [DW-1:0] clamp(input logic signed [DW:0] s);
    if (s[DW] != s[DW-1]) clamp = s[DW] ? MIN_V : MAX_V;
    else clamp = s[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
    sat_add = clamp({a[DW-1], a} + {b[DW-1], b});
  endfunction

  function automatic logic signed [DW-1:0] sat_sub(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
    sat_sub = clamp({a[DW-1], a} - {b[DW-1], b});
  endfunction

  // Floor-shift a raw product by FB and saturate.
  function automatic logic signed [DW-1:0] qscale(input logic signed [2*DW-1:0] p);
    logic [2*DW-FB-1:0] sh;
    sh = p[2*DW-1:FB];
    if (sh[2*DW-FB-1:DW-1] == '0 || sh[2*DW-FB-1:DW-1] == '1) qscale = sh[DW-1:0];
    else qscale = sh[2*DW-FB-1] ? MIN_V : MAX_V;
  endfunction

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
    mag = v[DW-1] ? DW'(-v) : v;
  endfunction

  // Apply sign to a quotient magnitude and saturate.
  function automatic logic signed [DW-1:0] div_sat(input logic [QW-1:0] q, input logic neg);
    if (neg) begin
      if (q > QW'({1'b1, {(DW-1){1'b0}}})) div_sat = MIN_V;
      else div_sat = DW'(~q[DW-1:0] + 1'b1);
    end else begin
      if (q > QW'(MAX_V)) div_sat = MAX_V;
      else div_sat = q[DW-1:0];
    end
  endfunction

endpackage

### hw/rtl/angle_bias_kalman_filter_core.sv
// Top level of the two-state angle and gyro bias Kalman filter.
//
//  channel  direction  handshake               payload
//  in       input      in_valid_i/in_ready_o   accel_angle_i, gyro_rate_i
//  out      output     out_valid_o/out_ready_i angle_estimate_o, bias_estimate_o
//  cfg      input      cfg_we_i (no wait)      cfg_idx_i, cfg_data_i
//
// Each item passes through acceptance, fifteen steps of the shared 32x32 multiplier (a
// multiply state and a write-back state each), the divider that forms both gains (a start
// state, 48 quotient bits and a hand-off) and the final step.
// Reset (asynchronous, active low) loads the default noise terms, unit covariance
// and zero angle and bias. An item is taken only when the controller is idle; a
// finished result waits in the output register, and the next item may be accepted
// while it waits. A stalled output holds the next result back in its final step.
module angle_bias_kalman_filter_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] accel_angle_i,
  input  logic signed [31:0] gyro_rate_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] angle_estimate_o,
  output logic signed [31:0] bias_estimate_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i
);
  abkf_pkg::cmd_t    cmd;
  abkf_pkg::status_t status;

  // Sequence the update.
  abkf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Hold state and do the arithmetic.
  abkf_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .accel_angle_i    (accel_angle_i),
    .gyro_rate_i      (gyro_rate_i),
    .angle_estimate_o (angle_estimate_o),
    .bias_estimate_o  (bias_estimate_o)
  );

endmodule

### hw/rtl/abkf_dp.sv
// Datapath: state, config registers, shared multiplier and two-lane divider.
module abkf_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  abkf_pkg::cmd_t      cmd_i,
  output abkf_pkg::status_t   status_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  logic signed [31:0]  accel_angle_i,
  input  logic signed [31:0]  gyro_rate_i,
  output logic signed [31:0]  angle_estimate_o,
  output logic signed [31:0]  bias_estimate_o
);
  localparam int DW = abkf_pkg::DW;
  localparam int FB = abkf_pkg::FB;
  localparam int QW = abkf_pkg::QW;
  localparam int CW = abkf_pkg::CW;

  logic [30:0] dt_q, qa_q, qb_q, rn_q;
  logic [31:0] c_q;
  logic signed [DW-1:0] aa_q, ab_q, ba_q, bb_q, ang_q, bias_q;
  logic signed [DW-1:0] acc_q, gyr_q, pc0_q, pc1_q, t1_q, e_q, err_q, k0_q, k1_q;
  logic signed [2*DW-1:0] p_q;
  logic signed [DW-1:0] ma, mb, pv, dt, qa, qb, rn, c;
  logic signed [31:0] out_ang_q, out_bias_q;

  logic [QW-1:0] dvd0_q, dvd1_q;
  logic [DW-1:0] rem0_q, rem1_q, den_q;
  logic          neg0_q, neg1_q, busy_q;
  logic          zero0_q, zero1_q;
  logic [CW-1:0] cnt_q;
  logic [DW:0]   r0_ext, r1_ext;
  logic          ge0, ge1;

  assign dt = {1'b0, dt_q};
  assign qa = {1'b0, qa_q};
  assign qb = {1'b0, qb_q};
  assign rn = {1'b0, rn_q};
  assign c  = c_q;
  assign pv = abkf_pkg::qscale(p_q);

  always_comb begin
    ma = c;
    mb = aa_q;
    case (cmd_i.op)
      abkf_pkg::OP_ANG_PRED: begin ma = abkf_pkg::sat_sub(gyr_q, bias_q); mb = dt; end
      abkf_pkg::OP_AA_PRED: begin
        ma = abkf_pkg::sat_sub(abkf_pkg::sat_sub(qa, ab_q), ba_q);
        mb = dt;
      end
      abkf_pkg::OP_AB_PRED,
      abkf_pkg::OP_BA_PRED: begin ma = abkf_pkg::sat_sub('0, bb_q); mb = dt; end
      abkf_pkg::OP_BB_PRED: begin ma = qb;   mb = dt;    end
      abkf_pkg::OP_PC0:     begin ma = c;    mb = aa_q;  end
      abkf_pkg::OP_PC1:     begin ma = c;    mb = ba_q;  end
      abkf_pkg::OP_T1:      begin ma = c;    mb = ab_q;  end
      abkf_pkg::OP_E:       begin ma = c;    mb = pc0_q; end
      abkf_pkg::OP_AA_UPD:  begin ma = k0_q; mb = pc0_q; end
      abkf_pkg::OP_AB_UPD:  begin ma = k0_q; mb = t1_q;  end
      abkf_pkg::OP_BA_UPD:  begin ma = k1_q; mb = pc0_q; end
      abkf_pkg::OP_BB_UPD:  begin ma = k1_q; mb = t1_q;  end
      abkf_pkg::OP_ANG_UPD: begin ma = k0_q; mb = err_q; end
      abkf_pkg::OP_BIAS_UPD: begin ma = k1_q; mb = err_q; end
      default: begin ma = c; mb = aa_q; end
    endcase
  end

  // Config registers and filter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q <= abkf_pkg::DT_RESET;
      qa_q <= abkf_pkg::QA_RESET;
      qb_q <= abkf_pkg::QB_RESET;
      rn_q <= abkf_pkg::RN_RESET;
      c_q  <= abkf_pkg::C_RESET;
      aa_q <= abkf_pkg::ONE_Q;
      ab_q <= '0;
      ba_q <= '0;
      bb_q <= abkf_pkg::ONE_Q;
      ang_q <= '0;
      bias_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (abkf_pkg::cfg_idx_e'(cfg_idx_i))
          abkf_pkg::CFG_TIME_STEP:     dt_q <= cfg_data_i[30:0];
          abkf_pkg::CFG_ANGLE_NOISE:   qa_q <= cfg_data_i[30:0];
          abkf_pkg::CFG_BIAS_NOISE:    qb_q <= cfg_data_i[30:0];
          abkf_pkg::CFG_MEASURE_NOISE: rn_q <= cfg_data_i[30:0];
          abkf_pkg::CFG_OBSERVE_GAIN:  c_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.wb_en) begin
        case (cmd_i.op)
          abkf_pkg::OP_ANG_PRED,
          abkf_pkg::OP_ANG_UPD:  ang_q  <= abkf_pkg::sat_add(ang_q, pv);
          abkf_pkg::OP_BIAS_UPD: bias_q <= abkf_pkg::sat_add(bias_q, pv);
          abkf_pkg::OP_AA_PRED:  aa_q   <= abkf_pkg::sat_add(aa_q, pv);
          abkf_pkg::OP_AB_PRED:  ab_q   <= abkf_pkg::sat_add(ab_q, pv);
          abkf_pkg::OP_BA_PRED:  ba_q   <= abkf_pkg::sat_add(ba_q, pv);
          abkf_pkg::OP_BB_PRED:  bb_q   <= abkf_pkg::sat_add(bb_q, pv);
          abkf_pkg::OP_AA_UPD:   aa_q   <= abkf_pkg::sat_sub(aa_q, pv);
          abkf_pkg::OP_AB_UPD:   ab_q   <= abkf_pkg::sat_sub(ab_q, pv);
          abkf_pkg::OP_BA_UPD:   ba_q   <= abkf_pkg::sat_sub(ba_q, pv);
          abkf_pkg::OP_BB_UPD:   bb_q   <= abkf_pkg::sat_sub(bb_q, pv);
          default: ;
        endcase
      end
    end
  end

  // Working values, product register and output payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      acc_q <= accel_angle_i;
      gyr_q <= gyro_rate_i;
    end
    if (cmd_i.mul_en) p_q <= ma * mb;
    if (cmd_i.wb_en) begin
      case (cmd_i.op)
        abkf_pkg::OP_PC0: pc0_q <= pv;
        abkf_pkg::OP_PC1: pc1_q <= pv;
        abkf_pkg::OP_T1:  t1_q  <= pv;
        abkf_pkg::OP_E: begin
          e_q   <= abkf_pkg::sat_add(rn, pv);
          err_q <= abkf_pkg::sat_sub(acc_q, ang_q);
        end
        default: ;
      endcase
    end
    if (cmd_i.div_wb) begin
      // a zero numerator gives a zero gain, even over a zero divisor
      k0_q <= zero0_q ? '0 : abkf_pkg::div_sat(dvd0_q, neg0_q);
      k1_q <= zero1_q ? '0 : abkf_pkg::div_sat(dvd1_q, neg1_q);
    end
    if (cmd_i.out_load) begin
      out_ang_q  <= ang_q;
      out_bias_q <= bias_q;
    end
  end

  // Restoring divider, one quotient bit per lane per cycle, common divisor.
  assign r0_ext = {rem0_q, dvd0_q[QW-1]};
  assign r1_ext = {rem1_q, dvd1_q[QW-1]};
  assign ge0 = r0_ext >= {1'b0, den_q};
  assign ge1 = r1_ext >= {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dvd0_q <= {abkf_pkg::mag(pc0_q), {FB{1'b0}}};
      dvd1_q <= {abkf_pkg::mag(pc1_q), {FB{1'b0}}};
      rem0_q <= '0;
      rem1_q <= '0;
      den_q  <= abkf_pkg::mag(e_q);
      neg0_q <= pc0_q[DW-1] ^ e_q[DW-1];
      neg1_q <= pc1_q[DW-1] ^ e_q[DW-1];
      zero0_q <= (pc0_q == '0);
      zero1_q <= (pc1_q == '0);
    end else if (busy_q) begin
      dvd0_q <= {dvd0_q[QW-2:0], ge0};
      dvd1_q <= {dvd1_q[QW-2:0], ge1};
      rem0_q <= ge0 ? DW'(r0_ext - {1'b0, den_q}) : r0_ext[DW-1:0];
      rem1_q <= ge1 ? DW'(r1_ext - {1'b0, den_q}) : r1_ext[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.div_start) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(QW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) busy_q <= 1'b0;
    end
  end

  assign status_o.div_busy = busy_q;
  assign angle_estimate_o  = out_ang_q;
  assign bias_estimate_o   = out_bias_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |=> busy_q && cnt_q == CW'(QW)) else $error("divider did not start");
  a_busy_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0) else $error("divider busy with empty count");
  a_wb_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_wb |-> !busy_q) else $error("quotient taken while dividing");

endmodule

### hw/rtl/abkf_ctrl.sv
// Controller: sequences the multiply steps, the division and the result hand-off.
module abkf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  abkf_pkg::status_t  status_i,
  output abkf_pkg::cmd_t     cmd_o
);
  abkf_pkg::state_e state_q, state_d;
  abkf_pkg::op_e    op_q, op_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= abkf_pkg::ST_IDLE;
      op_q        <= abkf_pkg::OP_ANG_PRED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '0;
    cmd_o.op = op_q;
    in_ready_o = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      abkf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          op_d    = abkf_pkg::OP_ANG_PRED;
          state_d = abkf_pkg::ST_MUL;
        end
      end
      abkf_pkg::ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d = abkf_pkg::ST_WB;
      end
      abkf_pkg::ST_WB: begin
        cmd_o.wb_en = 1'b1;
        if (op_q == abkf_pkg::OP_E) begin
          state_d = abkf_pkg::ST_DIVS;
        end else if (op_q == abkf_pkg::OP_BIAS_UPD) begin
          state_d = abkf_pkg::ST_FIN;
        end else begin
          op_d    = abkf_pkg::op_e'(op_q + 4'd1);
          state_d = abkf_pkg::ST_MUL;
        end
      end
      abkf_pkg::ST_DIVS: begin
        cmd_o.div_start = 1'b1;
        state_d = abkf_pkg::ST_DIV;
      end
      abkf_pkg::ST_DIV: begin
        if (!status_i.div_busy) begin
          cmd_o.div_wb = 1'b1;
          op_d    = abkf_pkg::op_e'(op_q + 4'd1);
          state_d = abkf_pkg::ST_MUL;
        end
      end
      abkf_pkg::ST_FIN: begin
        // hold until the output slot is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d = 1'b1;
          state_d = abkf_pkg::ST_IDLE;
        end
      end
      default: state_d = abkf_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i)) else $error("result overwritten");
  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == abkf_pkg::ST_MUL
      && op_q == abkf_pkg::OP_ANG_PRED) else $error("update did not start");
  a_div_after_e: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> $past(op_q) == abkf_pkg::OP_E) else $error("division out of order");

endmodule

### tb/tb.sv
// Self-checking testbench for the angle and gyro bias Kalman filter core.
module tb;

  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 150;   // longer than one item takes through the core
  localparam logic [2:0] CFG_SPARE_IDX = 3'd7;
  localparam logic [2:0] CFG_UNUSED_IDX = 3'd5;

  typedef struct {
    logic signed [31:0] accel;
    logic signed [31:0] gyro;
  } imu_item_t;

  typedef struct {
    logic signed [31:0] angle;
    logic signed [31:0] bias;
  } estimate_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] accel_angle_i = '0;
  logic signed [31:0] gyro_rate_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] angle_estimate_o;
  logic signed [31:0] bias_estimate_o;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [31:0]        cfg_data_i = '0;

  angle_bias_kalman_filter_core dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  imu_item_t pending_q[$];
  estimate_t estimate_q[$];
  int        fail_cnt = 0;
  bit        quiet = 1'b0;      // no idling on either side
  bit        long_hold = 1'b0;  // ask the receiver for one long stall

  // Filter copy: configuration and state in Q16.16
  longint dt_q, qa_q, qb_q, rn_q, c_q;
  longint ang_q, bias_q, paa, pab, pba, pbb;

  function automatic longint sat32(longint v);
    return v > VMAX ? VMAX : (v < VMIN ? VMIN : v);
  endfunction

  // Exact product, floor shift, saturate.
  function automatic longint fx_mul(longint a, longint b);
    longint p;
    p = a * b;
    return sat32(p >>> 16);
  endfunction

  // Quotient truncated toward zero; a zero divisor saturates by numerator sign.
  function automatic longint fx_div(longint a, longint b);
    longint n, d, q;
    bit neg;
    neg = (a < 0) != (b < 0);
    n = a < 0 ? -a : a;
    d = b < 0 ? -b : b;
    if (n == 0) return 0;
    if (d == 0) return a < 0 ? VMIN : VMAX;
    q = (n << 16) / d;
    if (neg) return q > VMAX + 1 ? VMIN : -q;
    return q > VMAX ? VMAX : q;
  endfunction

  task automatic filter_reset();
    dt_q = longint'(abkf_pkg::DT_RESET);
    qa_q = longint'(abkf_pkg::QA_RESET);
    qb_q = longint'(abkf_pkg::QB_RESET);
    rn_q = longint'(abkf_pkg::RN_RESET);
    c_q = longint'($signed(abkf_pkg::C_RESET));
    ang_q = 0; bias_q = 0; paa = 65536; pab = 0; pba = 0; pbb = 65536;
  endtask

  task automatic filter_step(imu_item_t it, output estimate_t est);
    longint acc, gyr, d0, dn, err, pc0, pc1, e, k0, k1, t1;
    acc = it.accel;
    gyr = it.gyro;
    ang_q = sat32(ang_q + fx_mul(sat32(gyr - bias_q), dt_q));
    d0 = sat32(sat32(qa_q - pab) - pba);
    dn = sat32(-pbb);
    paa = sat32(paa + fx_mul(d0, dt_q));
    pab = sat32(pab + fx_mul(dn, dt_q));
    pba = sat32(pba + fx_mul(dn, dt_q));
    pbb = sat32(pbb + fx_mul(qb_q, dt_q));
    err = sat32(acc - ang_q);
    pc0 = fx_mul(c_q, paa);
    pc1 = fx_mul(c_q, pba);
    e = sat32(rn_q + fx_mul(c_q, pc0));
    k0 = fx_div(pc0, e);
    k1 = fx_div(pc1, e);
    t1 = fx_mul(c_q, pab);
    paa = sat32(paa - fx_mul(k0, pc0));
    pab = sat32(pab - fx_mul(k0, t1));
    pba = sat32(pba - fx_mul(k1, pc0));
    pbb = sat32(pbb - fx_mul(k1, t1));
    ang_q = sat32(ang_q + fx_mul(k0, err));
    bias_q = sat32(bias_q + fx_mul(k1, err));
    est.angle = 32'(ang_q);
    est.bias = 32'(bias_q);
  endtask

  // Driver: offer pending items, run the filter copy on acceptance, idle in random bursts.
  int send_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    estimate_t est;
    imu_item_t it;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        it.accel = accel_angle_i;
        it.gyro = gyro_rate_i;
        filter_step(it, est);
        estimate_q.push_back(est);
      end
      if (in_valid_i && !in_ready_o) begin
        // hold the item until it is taken
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_q.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        send_gap <= $urandom_range(1, 13) - 1;
        in_valid_i <= 1'b0;
      end else begin
        it = pending_q.pop_front();
        in_valid_i <= 1'b1;
        accel_angle_i <= it.accel;
        gyro_rate_i <= it.gyro;
      end
    end
  end

  // Monitor: stall in bursts, once for a long stretch; check each result.
  int recv_gap = 0;
  int hold_cnt = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    estimate_t exp_e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (estimate_q.size() == 0) begin
          $display("%0t: unexpected result angle=%0d bias=%0d", $realtime,
                   angle_estimate_o, bias_estimate_o);
          fail_cnt++;
        end else begin
          exp_e = estimate_q.pop_front();
          if (angle_estimate_o !== exp_e.angle) begin
            $display("%0t: angle expected %0d actual %0d", $realtime, exp_e.angle,
                     angle_estimate_o);
            fail_cnt++;
          end
          if (bias_estimate_o !== exp_e.bias) begin
            $display("%0t: bias expected %0d actual %0d", $realtime, exp_e.bias,
                     bias_estimate_o);
            fail_cnt++;
          end
        end
      end
      if (long_hold && hold_cnt < 600) begin
        // hold off long enough for the core to fill and stall its input
        hold_cnt <= hold_cnt + 1;
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        recv_gap <= $urandom_range(1, 13) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog
  int cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      abkf_pkg::CFG_TIME_STEP:     dt_q = longint'(data[30:0]);
      abkf_pkg::CFG_ANGLE_NOISE:   qa_q = longint'(data[30:0]);
      abkf_pkg::CFG_BIAS_NOISE:    qb_q = longint'(data[30:0]);
      abkf_pkg::CFG_MEASURE_NOISE: rn_q = longint'(data[30:0]);
      abkf_pkg::CFG_OBSERVE_GAIN:  c_q = longint'($signed(data));
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic cfg_all(logic [31:0] dt, logic [31:0] qa, logic [31:0] qb,
                         logic [31:0] rn, logic [31:0] c);
    cfg_write(abkf_pkg::CFG_TIME_STEP, dt);
    cfg_write(abkf_pkg::CFG_ANGLE_NOISE, qa);
    cfg_write(abkf_pkg::CFG_BIAS_NOISE, qb);
    cfg_write(abkf_pkg::CFG_MEASURE_NOISE, rn);
    cfg_write(abkf_pkg::CFG_OBSERVE_GAIN, c);
  endtask

  // Let every item already queued come back, then let the core go idle.
  task automatic drain();
    while (pending_q.size() != 0 || in_valid_i || estimate_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic push(logic [31:0] a, logic [31:0] g);
    imu_item_t it;
    it.accel = a;
    it.gyro = g;
    pending_q.push_back(it);
  endtask

  // Mostly plausible IMU samples, with some full-range noise.
  task automatic push_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0)
        push($urandom, $urandom);
      else
        push(32'($signed($urandom_range(0, 1 << 24)) - (1 << 23)),
             32'($signed($urandom_range(0, 1 << 22)) - (1 << 21)));
    end
  endtask

  task automatic cfg_defaults();
    cfg_all(32'(abkf_pkg::DT_RESET), 32'(abkf_pkg::QA_RESET), 32'(abkf_pkg::QB_RESET),
            32'(abkf_pkg::RN_RESET), abkf_pkg::C_RESET);
  endtask

  initial begin
    filter_reset();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes at default settings
    push(32'h0000_0000, 32'h0000_0000);
    push(32'h7fff_ffff, 32'h7fff_ffff);
    push(32'h8000_0000, 32'h8000_0000);
    push(32'h7fff_ffff, 32'h8000_0000);
    push(32'h8000_0000, 32'h7fff_ffff);
    push(32'hffff_ffff, 32'h0000_0001);
    push(32'h0001_0000, 32'hffff_0000);
    push(32'h0000_0000, 32'h0000_0000);
    drain();

    // Zero measurement noise and zero gain: zero innovation variance
    cfg_all(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h0);
    cfg_write(CFG_SPARE_IDX, 32'hffff_ffff);
    cfg_write(CFG_UNUSED_IDX, 32'h1234_5678);
    push(32'h7fff_ffff, 32'h7fff_ffff);
    push(32'h8000_0000, 32'h8000_0000);
    push(32'h0000_0000, 32'h0000_0001);
    drain();
    cfg_all(32'h0, 32'h0, 32'h0, 32'h1, 32'h8000_0000);
    push(32'h7fff_ffff, 32'h8000_0000);
    push(32'h8000_0000, 32'h7fff_ffff);
    push(32'h0001_0000, 32'h0001_0000);
    drain();
    // bit 31 set on the narrow registers is dropped
    cfg_all(32'hffff_ffff, 32'h8000_0001, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff);
    push(32'h7fff_ffff, 32'h7fff_ffff);
    push(32'h8000_0000, 32'h0);
    push(32'h1234_5678, 32'hedcb_a987);
    drain();

    // Random phases across settings
    cfg_defaults();
    long_hold = 1'b1;
    push_random(260);
    drain();
    cfg_all(32'd655, 32'd65536, 32'd100, 32'd6554, 32'hffff_0000);
    push_random(260);
    drain();
    cfg_all($urandom, $urandom, $urandom, $urandom, $urandom);
    push_random(260);
    drain();
    cfg_all(32'd1, 32'd1, 32'd1, 32'h7fff_ffff, 32'h8000_0000);
    push_random(260);
    drain();
    cfg_all(32'h0001_0000, 32'h0, 32'h0, 32'd1, 32'h0002_0000);
    push_random(260);
    drain();
    cfg_all($urandom_range(0, 2000), $urandom_range(0, 1 << 17),
            $urandom_range(0, 1 << 17), $urandom_range(1, 1 << 17), $urandom);
    push_random(260);
    drain();
    // last stretch runs without idling
    cfg_defaults();
    quiet = 1'b1;
    push_random(300);
    drain();

    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
